### rtl/core/pcx_rle_line_decoder_core_assert.svh
// Assertion macros used by the back end of the run-length line decoder.
`ifndef PCX_RLE_LINE_DECODER_CORE_ASSERT_SVH
`define PCX_RLE_LINE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcx_rld: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcx_rld: next-cycle check failed");

`endif

### rtl/core/pcx_rld_pkg.sv
// Package with the types and constants of the run-length line decoder.
`timescale 1ns / 1ps
`default_nettype none
package pcx_rld_pkg;

	localparam logic [7:0] HeaderMask = 8'hC0;
	localparam logic [7:0] CountMask = 8'h3F;

	localparam logic [13:0] MaxLineBytes = 14'd8192;
	localparam logic [12:0] MaxRows = 13'd4096;

	localparam logic [1:0] REG_LINE_BYTES = 2'd0;
	localparam logic [1:0] REG_IMAGE_ROWS = 2'd1;
	localparam logic [1:0] REG_INVERT_OUTPUT = 2'd2;

	typedef struct packed {
		logic [7:0] value;
		logic [5:0] count;
	} cmd_t;

	typedef struct packed {
		logic [13:0] line_bytes;
		logic [12:0] image_rows;
		logic invert_output;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic valid;
	} fifo_status_t;

endpackage
`default_nettype wire

### rtl/core/pcx_rld_fifo.sv
// Two-entry command queue between the decoder front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module pcx_rld_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire pcx_rld_pkg::cmd_t push_data,
	input wire logic pop,
	output pcx_rld_pkg::cmd_t pop_data,
	output pcx_rld_pkg::fifo_status_t status
);

	pcx_rld_pkg::cmd_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign status.full = (count_q == 2'd2);
	assign status.valid = (count_q != 2'd0);
	assign do_push = push && !status.full;
	assign do_pop = pop && status.valid;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

### rtl/core/pcx_rld_front.sv
// Front end: takes code bytes and turns them into emit commands for the queue.
`timescale 1ns / 1ps
`default_nettype none
module pcx_rld_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] code_byte,
	input wire pcx_rld_pkg::fifo_status_t fifo_status,
	output logic push,
	output pcx_rld_pkg::cmd_t push_data
);

	logic await_q;
	logic [5:0] pending_q;
	logic accept;
	logic is_header;

	assign in_stall = fifo_status.full;
	assign accept = in_valid && !in_stall;
	assign is_header = ((code_byte & pcx_rld_pkg::HeaderMask) == pcx_rld_pkg::HeaderMask);

	always_comb begin
		push_data.value = code_byte;
		if (await_q) begin
			push_data.count = pending_q;
			push = accept && (pending_q != 6'd0);
		end else begin
			push_data.count = 6'd1;
			push = accept && !is_header;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q <= 1'b0;
			pending_q <= 6'd0;
		end else if (accept) begin
			if (await_q) begin
				await_q <= 1'b0;
				pending_q <= 6'd0;
			end else if (is_header) begin
				await_q <= 1'b1;
				pending_q <= code_byte[5:0] & pcx_rld_pkg::CountMask[5:0];
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/pcx_rld_back.sv
// Back end: expands commands into bytes, tracks line and frame position.
`timescale 1ns / 1ps
`default_nettype none
`include "pcx_rle_line_decoder_core_assert.svh"
module pcx_rld_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire pcx_rld_pkg::cfg_t cfg,
	input wire pcx_rld_pkg::fifo_status_t fifo_status,
	input wire pcx_rld_pkg::cmd_t pop_data,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] pixel_byte,
	output logic line_end,
	output logic frame_end,
	output logic last
);

	logic act_q;
	logic [7:0] val_q;
	logic [5:0] rem_q;
	logic [12:0] col_q;
	logic [11:0] row_q;
	logic out_valid_q;
	logic [7:0] pixel_q;
	logic line_end_q;
	logic frame_end_q;
	logic last_q;

	logic [13:0] line_len;
	logic [12:0] rows;
	logic out_free;
	logic emit;
	logic le;
	logic fe;
	logic is_last;

	always_comb begin
		if (cfg.line_bytes == 14'd0) begin
			line_len = 14'd1;
		end else if (cfg.line_bytes > pcx_rld_pkg::MaxLineBytes) begin
			line_len = pcx_rld_pkg::MaxLineBytes;
		end else begin
			line_len = cfg.line_bytes;
		end
		if (cfg.image_rows == 13'd0) begin
			rows = 13'd1;
		end else if (cfg.image_rows > pcx_rld_pkg::MaxRows) begin
			rows = pcx_rld_pkg::MaxRows;
		end else begin
			rows = cfg.image_rows;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign emit = act_q && out_free;
	assign le = (({1'b0, col_q} + 14'd1) >= line_len);
	assign fe = le && (({1'b0, row_q} + 13'd1) >= rows);
	assign is_last = le || (rem_q == 6'd1);
	assign pop = fifo_status.valid && (!act_q || (emit && is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			rem_q <= 6'd0;
			col_q <= 13'd0;
			row_q <= 12'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				act_q <= 1'b1;
				rem_q <= pop_data.count;
			end else if (emit && is_last) begin
				act_q <= 1'b0;
				rem_q <= 6'd0;
			end else if (emit) begin
				rem_q <= rem_q - 6'd1;
			end
			if (emit) begin
				if (le) begin
					col_q <= 13'd0;
					row_q <= fe ? 12'd0 : row_q + 12'd1;
				end else begin
					col_q <= col_q + 13'd1;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			val_q <= pop_data.value;
		end
		if (emit) begin
			pixel_q <= val_q ^ {8{cfg.invert_output}};
			line_end_q <= le;
			frame_end_q <= fe;
			last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_byte = pixel_q;
	assign line_end = line_end_q;
	assign frame_end = frame_end_q;
	assign last = last_q;

	`PCX_ASSERT_NOW(a_active_has_count, clk, arst_n, act_q, rem_q != 6'd0)
	`PCX_ASSERT_NEXT(a_line_end_wraps_column, clk, arst_n, emit && le, col_q == 13'd0)
	`PCX_ASSERT_NOW(a_frame_end_on_line_end, clk, arst_n, out_valid_q && frame_end_q, line_end_q)
	`PCX_ASSERT_NEXT(a_line_end_is_last, clk, arst_n, emit && le, last_q && !act_q || last_q && act_q)

endmodule
`default_nettype wire

### rtl/core/pcx_rle_line_decoder_core.sv
// Top level of the run-length line decoder: configuration registers and the datapath.
// A literal byte passes through the command queue, the back end value register and the
// output register. A run header and its value byte take two input transfers; the run
// then emits one byte per cycle when not stalled, up to 63 bytes, cut short at the end
// of a scan line. Throughput: one output byte per cycle when not stalled, set by the
// back end emit loop; input transfers stall while the two-entry command queue is full.
// Reset: asynchronous, clears all counters and queues; registers return to 80, 350, 0.
`timescale 1ns / 1ps
`default_nettype none
module pcx_rle_line_decoder_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] code_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] pixel_byte,
	output logic line_end,
	output logic frame_end,
	output logic last,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [13:0] cfg_data
);

	pcx_rld_pkg::cfg_t cfg_q;
	pcx_rld_pkg::fifo_status_t fifo_status;
	pcx_rld_pkg::cmd_t push_data;
	pcx_rld_pkg::cmd_t pop_data;
	logic push;
	logic pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_bytes <= 14'd80;
			cfg_q.image_rows <= 13'd350;
			cfg_q.invert_output <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pcx_rld_pkg::REG_LINE_BYTES: begin
					cfg_q.line_bytes <= cfg_data;
				end
				pcx_rld_pkg::REG_IMAGE_ROWS: begin
					cfg_q.image_rows <= cfg_data[12:0];
				end
				pcx_rld_pkg::REG_INVERT_OUTPUT: begin
					cfg_q.invert_output <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	pcx_rld_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_byte(code_byte),
		.fifo_status(fifo_status),
		.push(push),
		.push_data(push_data)
	);

	pcx_rld_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(pop_data),
		.status(fifo_status)
	);

	pcx_rld_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.fifo_status(fifo_status),
		.pop_data(pop_data),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_byte(pixel_byte),
		.line_end(line_end),
		.frame_end(frame_end),
		.last(last)
	);

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the run-length line decoder core.
`timescale 1ns / 1ps
module tb_top;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 70;
	localparam int STUCK_LIMIT = 3000;

	typedef struct packed {
		logic [7:0] pixel;
		logic le;
		logic fe;
		logic lst;
	} pixel_res_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_QUIET, ROW_TYPED, ROW_MODEL} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [1:0] idx;
		logic [13:0] data;
		logic [7:0] code;
		logic [7:0] pix;
		logic le;
		logic fe;
		logic lst;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] code_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] pixel_byte;
	logic line_end;
	logic frame_end;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = 2'd0;
	logic [13:0] cfg_data = 14'd0;

	pixel_res_t pixel_q[$];
	pixel_res_t run_q[$];
	dir_row_t dir_q[$];

	logic [13:0] cur_bpl;
	logic [12:0] cur_rows;
	logic cur_inv;
	logic await_run;
	logic [5:0] run_len;
	logic [12:0] col_cnt;
	logic [11:0] row_cnt;

	int gap_pct = 0;
	int stall_pct = 0;
	int err_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int line_count = 0;
	int frame_count = 0;
	int write_count = 0;
	int stuck_cycles = 0;

	pcx_rle_line_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_byte(code_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_byte(pixel_byte),
		.line_end(line_end),
		.frame_end(frame_end),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic emit_pixel(input logic [7:0] value);
		int unsigned line_len;
		int unsigned frame_rows;
		logic le;
		logic fe;
		pixel_res_t r;
		line_len = (cur_bpl == 0) ? 1 :
			((cur_bpl > pcx_rld_pkg::MaxLineBytes) ? pcx_rld_pkg::MaxLineBytes : cur_bpl);
		frame_rows = (cur_rows == 0) ? 1 :
			((cur_rows > pcx_rld_pkg::MaxRows) ? pcx_rld_pkg::MaxRows : cur_rows);
		le = (int'(col_cnt) + 1 >= line_len);
		fe = 1'b0;
		if (le) begin
			col_cnt = 0;
			if (int'(row_cnt) + 1 >= frame_rows) begin
				fe = 1'b1;
				row_cnt = 0;
			end else begin
				row_cnt = row_cnt + 1;
			end
		end else begin
			col_cnt = col_cnt + 1;
		end
		r.pixel = cur_inv ? ~value : value;
		r.le = le;
		r.fe = fe;
		r.lst = 1'b0;
		run_q.push_back(r);
		return le;
	endfunction

	task automatic decode_code(input logic [7:0] b);
		logic [7:0] masked;
		pixel_res_t r;
		int n;
		run_q.delete();
		if (await_run) begin
			n = run_len;
			await_run = 1'b0;
			run_len = 6'd0;
			for (int k = 0; k < n; k++) begin
				if (emit_pixel(b))
					break;
			end
		end else if ((b & pcx_rld_pkg::HeaderMask) == pcx_rld_pkg::HeaderMask) begin
			masked = b & pcx_rld_pkg::CountMask;
			await_run = 1'b1;
			run_len = masked[5:0];
		end else begin
			void'(emit_pixel(b));
		end
		if (run_q.size() > 0) begin
			r = run_q.pop_back();
			r.lst = 1'b1;
			run_q.push_back(r);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input bit from_model);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= b;
		do @(posedge clk); while (in_stall);
		sent_count++;
		decode_code(b);
		if (from_model) begin
			foreach (run_q[i])
				pixel_q.push_back(run_q[i]);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
		in_valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		write_count++;
		case (idx)
			pcx_rld_pkg::REG_LINE_BYTES: cur_bpl = data;
			pcx_rld_pkg::REG_IMAGE_ROWS: cur_rows = data[12:0];
			pcx_rld_pkg::REG_INVERT_OUTPUT: cur_inv = data[0];
			default: ;
		endcase
	endtask

	task automatic run_phase(input int gap, input int stall, input int n_items);
		int sent;
		int pick;
		logic [7:0] header;
		gap_pct = gap;
		stall_pct = stall;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_byte(8'($urandom_range(0, 191)), 1'b1);
				sent++;
			end else if (pick < 90) begin
				header = pcx_rld_pkg::HeaderMask | 8'($urandom_range(0, 63));
				send_byte(header, 1'b1);
				send_byte(8'($urandom_range(0, 255)), 1'b1);
				sent += 2;
			end else begin
				send_byte(8'($urandom_range(0, 255)), 1'b1);
				sent++;
			end
		end
	endtask

	function automatic void dir_write(input logic [1:0] idx, input logic [13:0] data);
		dir_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		dir_q.push_back(r);
	endfunction

	function automatic void dir_byte(input row_kind_t kind, input logic [7:0] code,
			input logic [7:0] pix, input logic le, input logic fe, input logic lst);
		dir_row_t r;
		r = '0;
		r.kind = kind;
		r.code = code;
		r.pix = pix;
		r.le = le;
		r.fe = fe;
		r.lst = lst;
		dir_q.push_back(r);
	endfunction

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin : check_results
		pixel_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_q.size() == 0) begin
				$error("Unexpected result: pixel_byte %02h line_end %0b frame_end %0b last %0b",
					pixel_byte, line_end, frame_end, last);
				err_count++;
			end else begin
				want = pixel_q.pop_front();
				if (pixel_byte !== want.pixel) begin
					$error("pixel_byte: expected %02h, got %02h", want.pixel, pixel_byte);
					err_count++;
				end
				if (line_end !== want.le) begin
					$error("line_end: expected %0b, got %0b", want.le, line_end);
					err_count++;
				end
				if (frame_end !== want.fe) begin
					$error("frame_end: expected %0b, got %0b", want.fe, frame_end);
					err_count++;
				end
				if (last !== want.lst) begin
					$error("last: expected %0b, got %0b", want.lst, last);
					err_count++;
				end
				checked_count++;
				if (want.le)
					line_count++;
				if (want.fe)
					frame_count++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", STUCK_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		dir_row_t row;
		pixel_res_t typed;
		cur_bpl = 14'd80;
		cur_rows = 13'd350;
		cur_inv = 1'b0;
		await_run = 1'b0;
		run_len = 6'd0;
		col_cnt = 13'd0;
		row_cnt = 12'd0;

		// Literals, headers, zero and full runs, and a run cut at the end of a line.
		dir_byte(ROW_TYPED, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
		dir_byte(ROW_TYPED, 8'hBF, 8'hBF, 1'b0, 1'b0, 1'b1);
		dir_byte(ROW_TYPED, 8'h7F, 8'h7F, 1'b0, 1'b0, 1'b1);
		dir_byte(ROW_QUIET, 8'hC0, 8'h00, 1'b0, 1'b0, 1'b0);
		dir_byte(ROW_QUIET, 8'h55, 8'h00, 1'b0, 1'b0, 1'b0);
		dir_byte(ROW_QUIET, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0);
		dir_byte(ROW_MODEL, 8'hA5, 8'h00, 1'b0, 1'b0, 1'b0);
		dir_byte(ROW_QUIET, 8'hC1, 8'h00, 1'b0, 1'b0, 1'b0);
		dir_byte(ROW_TYPED, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1);
		dir_byte(ROW_QUIET, 8'hC2, 8'h00, 1'b0, 1'b0, 1'b0);
		dir_byte(ROW_MODEL, 8'hC0, 8'h00, 1'b0, 1'b0, 1'b0);
		dir_byte(ROW_QUIET, 8'hCF, 8'h00, 1'b0, 1'b0, 1'b0);
		dir_byte(ROW_MODEL, 8'h3C, 8'h00, 1'b0, 1'b0, 1'b0);
		dir_write(pcx_rld_pkg::REG_INVERT_OUTPUT, 14'd1);
		dir_write(pcx_rld_pkg::REG_LINE_BYTES, 14'd1);
		dir_byte(ROW_MODEL, 8'h01, 8'h00, 1'b0, 1'b0, 1'b0);
		dir_byte(ROW_MODEL, 8'h80, 8'h00, 1'b0, 1'b0, 1'b0);
		dir_byte(ROW_MODEL, 8'h40, 8'h00, 1'b0, 1'b0, 1'b0);
		// The row limit drops below the current row, so the next line ends the frame.
		dir_write(pcx_rld_pkg::REG_IMAGE_ROWS, 14'd2);
		dir_byte(ROW_TYPED, 8'h20, 8'hDF, 1'b1, 1'b1, 1'b1);
		dir_write(pcx_rld_pkg::REG_LINE_BYTES, 14'd0);
		dir_write(pcx_rld_pkg::REG_IMAGE_ROWS, 14'd0);
		dir_byte(ROW_TYPED, 8'h10, 8'hEF, 1'b1, 1'b1, 1'b1);
		dir_byte(ROW_QUIET, 8'hC3, 8'h00, 1'b0, 1'b0, 1'b0);
		dir_byte(ROW_TYPED, 8'h0F, 8'hF0, 1'b1, 1'b1, 1'b1);
		dir_write(pcx_rld_pkg::REG_INVERT_OUTPUT, 14'd0);
		dir_write(pcx_rld_pkg::REG_LINE_BYTES, 14'd40);
		dir_byte(ROW_MODEL, 8'h04, 8'h00, 1'b0, 1'b0, 1'b0);
		dir_byte(ROW_MODEL, 8'h08, 8'h00, 1'b0, 1'b0, 1'b0);
		// The line length drops below the current column.
		dir_write(pcx_rld_pkg::REG_LINE_BYTES, 14'd2);
		dir_byte(ROW_TYPED, 8'h02, 8'h02, 1'b1, 1'b1, 1'b1);
		dir_write(REG_UNUSED, 14'h3FFF);
		dir_byte(ROW_TYPED, 8'h01, 8'h01, 1'b0, 1'b0, 1'b1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < dir_q.size(); i++) begin
			row = dir_q[i];
			case (row.kind)
				ROW_WRITE: write_reg(row.idx, row.data);
				ROW_QUIET: send_byte(row.code, 1'b0);
				ROW_TYPED: begin
					send_byte(row.code, 1'b0);
					typed.pixel = row.pix;
					typed.le = row.le;
					typed.fe = row.fe;
					typed.lst = row.lst;
					pixel_q.push_back(typed);
				end
				default: send_byte(row.code, 1'b1);
			endcase
		end

		write_reg(pcx_rld_pkg::REG_LINE_BYTES, 14'd3);
		write_reg(pcx_rld_pkg::REG_IMAGE_ROWS, 14'd2);
		run_phase(0, 0, 76);
		write_reg(pcx_rld_pkg::REG_LINE_BYTES, 14'h3FFF);
		write_reg(pcx_rld_pkg::REG_IMAGE_ROWS, 14'd8191);
		write_reg(pcx_rld_pkg::REG_INVERT_OUTPUT, 14'd1);
		run_phase(57, 0, 76);
		write_reg(pcx_rld_pkg::REG_LINE_BYTES, 14'd7);
		write_reg(pcx_rld_pkg::REG_IMAGE_ROWS, 14'd5);
		write_reg(pcx_rld_pkg::REG_INVERT_OUTPUT, 14'd0);
		run_phase(0, 57, 76);
		write_reg(pcx_rld_pkg::REG_LINE_BYTES, 14'd0);
		write_reg(pcx_rld_pkg::REG_IMAGE_ROWS, 14'd0);
		write_reg(pcx_rld_pkg::REG_INVERT_OUTPUT, 14'd1);
		run_phase(22, 22, 76);
		write_reg(pcx_rld_pkg::REG_LINE_BYTES, 14'd100);
		write_reg(pcx_rld_pkg::REG_IMAGE_ROWS, 14'h3FFF);
		write_reg(REG_UNUSED, 14'd0);
		run_phase(0, 0, 76);
		write_reg(pcx_rld_pkg::REG_LINE_BYTES, 14'd13);
		write_reg(pcx_rld_pkg::REG_IMAGE_ROWS, 14'd4096);
		write_reg(pcx_rld_pkg::REG_INVERT_OUTPUT, 14'd0);
		run_phase(22, 22, 76);

		in_valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d code bytes and made %0d register writes.", sent_count, write_count);
		$display("Checked %0d pixel bytes, %0d line ends and %0d frame ends.",
			checked_count, line_count, frame_count);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
